// ===== rtl/nsfe_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the NMEA field extractor.
// No dependencies; imported by nsfe_decode, nsfe_out_stage and the top level.
package nsfe_pkg;

    // Parser phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

    // Configuration register indexes.
    localparam logic CFG_ENABLE_RMC = 1'b0;
    localparam logic CFG_ENABLE_GGA = 1'b1;

    // Result kinds and sentence types.
    localparam logic KIND_CHAR     = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;
    localparam logic TYPE_RMC      = 1'b0;
    localparam logic TYPE_GGA      = 1'b1;

    // Field codes.
    localparam logic [2:0] FC_TIME   = 3'd0;
    localparam logic [2:0] FC_LAT    = 3'd1;
    localparam logic [2:0] FC_LON    = 3'd2;
    localparam logic [2:0] FC_SPEED  = 3'd3;
    localparam logic [2:0] FC_COURSE = 3'd4;
    localparam logic [2:0] FC_DATE   = 3'd5;
    localparam logic [2:0] FC_SATS   = 3'd6;
    localparam logic [2:0] FC_ALT    = 3'd7;

    // Characters of interest.
    localparam logic [7:0] CH_START = 8'h24;  // '$'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','

    localparam logic [2:0] HDR_LEN    = 3'd5;
    localparam logic [3:0] LAST_COMMA = 4'd10;

    // Sequencer state other than the field position.
    typedef struct packed {
        phase_t     phase;
        logic [2:0] header_count;
        logic       match_rmc;
        logic       match_gga;
        logic [3:0] comma_count;
    } parse_state_t;

    // One result word.
    typedef struct packed {
        logic       kind;
        logic       sent_type;
        logic [2:0] code;
        logic [3:0] pos;
        logic [7:0] value;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } field_sel_t;

    // Expected header characters, "GPRMC".
    function automatic logic [7:0] hdr_rmc_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47;  // G
            3'd1:    c = 8'h50;  // P
            3'd2:    c = 8'h52;  // R
            3'd3:    c = 8'h4D;  // M
            default: c = 8'h43;  // C
        endcase
        return c;
    endfunction

    // Expected header characters, "GPGGA".
    function automatic logic [7:0] hdr_gga_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47;  // G
            3'd1:    c = 8'h50;  // P
            3'd2:    c = 8'h47;  // G
            3'd3:    c = 8'h47;  // G
            default: c = 8'h41;  // A
        endcase
        return c;
    endfunction

    // Field selected by the number of commas seen so far.
    function automatic field_sel_t field_for(input logic gga, input logic [3:0] cnt);
        field_sel_t f;
        f.hit  = 1'b1;
        f.code = FC_TIME;
        if (!gga) begin
            case (cnt)
                4'd1:          f.code = FC_TIME;
                4'd3, 4'd4:    f.code = FC_LAT;
                4'd5, 4'd6:    f.code = FC_LON;
                4'd7:          f.code = FC_SPEED;
                4'd8:          f.code = FC_COURSE;
                4'd9:          f.code = FC_DATE;
                default:       f.hit  = 1'b0;
            endcase
        end
        else begin
            case (cnt)
                4'd7:    f.code = FC_SATS;
                4'd9:    f.code = FC_ALT;
                default: f.hit  = 1'b0;
            endcase
        end
        return f;
    endfunction

endpackage

// ===== rtl/nmea_sentence_field_extractor_top.sv =====
`timescale 1ns / 1ps
// Top level of the NMEA RMC/GGA field extractor.
// Depends on nsfe_pkg, nsfe_decode and nsfe_out_stage.
//
// The block takes one received ASCII byte per word on the input channel and
// emits at most one result word per byte. A '$' opens a sentence; the five
// bytes after it are compared with "GPRMC" and "GPGGA", and a matching sentence
// whose type is enabled is scanned field by field. Characters of the chosen
// fields come out with a field code and their position in the field; in RMC
// the N/S and E/W letters continue the latitude and longitude fields. The
// tenth comma produces a sentence-complete word. Characters beyond
// MAX_FIELD_LEN in one field are dropped. The block accepts one byte every
// clock cycle while out_ready does not hold back the output register; a byte
// passes an input register, is decoded against the parser state, and its
// result lands in the output register. The output register decouples the
// two sides: a new byte is taken while a finished result still waits for
// out_ready. The enable registers are read when a header completes and are
// written through cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle, which the block itself does not enforce.
module nmea_sentence_field_extractor_top #(
    parameter int MAX_FIELD_LEN = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       result_kind,
    output logic       sentence_type,
    output logic [2:0] field_code,
    output logic [3:0] char_pos,
    output logic [7:0] char_value
);
    import nsfe_pkg::*;

    localparam int POS_W = $clog2(MAX_FIELD_LEN + 1);

    // Configuration registers.
    logic enable_rmc_reg;
    logic enable_gga_reg;

    // Input register.
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_byte_reg;

    // Parser state.
    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;

    logic    dec_emit;
    result_t dec_result;
    logic    can_load;
    logic    s1_fire;
    logic    in_take;
    result_t out_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            enable_rmc_reg <= 1'b1;
            enable_gga_reg <= 1'b1;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLE_RMC: enable_rmc_reg <= cfg_data;
                CFG_ENABLE_GGA: enable_gga_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // The held byte is decoded when the result register can take its outcome.
    assign s1_fire  = s1_valid_reg & can_load;
    assign in_ready = ~s1_valid_reg | s1_fire;
    assign in_take  = in_valid & in_ready;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_byte_reg <= in_byte;
    end

    nsfe_decode #(
        .MAX_FIELD_LEN (MAX_FIELD_LEN),
        .POS_W         (POS_W)
    ) u_decode (
        .rx_byte       (s1_byte_reg),
        .state         (state_reg),
        .position      (position_reg),
        .enable_rmc    (enable_rmc_reg),
        .enable_gga    (enable_gga_reg),
        .state_next    (state_next),
        .position_next (position_next),
        .emit          (dec_emit),
        .result        (dec_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.phase        <= PH_IDLE;
            state_reg.header_count <= 3'd0;
            state_reg.match_rmc    <= 1'b1;
            state_reg.match_gga    <= 1'b1;
            state_reg.comma_count  <= 4'd0;
            position_reg           <= '0;
        end
        else if (s1_fire) begin
            state_reg    <= state_next;
            position_reg <= position_next;
        end
    end

    nsfe_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_fire),
        .load_emit   (dec_emit),
        .load_result (dec_result),
        .out_ready   (out_ready),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_result  (out_result)
    );

    assign result_kind   = out_result.kind;
    assign sentence_type = out_result.sent_type;
    assign field_code    = out_result.code;
    assign char_pos      = out_result.pos;
    assign char_value    = out_result.value;

endmodule

// ===== rtl/nsfe_decode.sv =====
`timescale 1ns / 1ps
// Per-byte decode: next parser state, next field position and the result word.
// Depends on nsfe_pkg.
module nsfe_decode #(
    parameter int MAX_FIELD_LEN = 16,
    parameter int POS_W = $clog2(MAX_FIELD_LEN + 1)
) (
    input  logic [7:0]                 rx_byte,
    input  nsfe_pkg::parse_state_t     state,
    input  logic [POS_W-1:0]           position,
    input  logic                       enable_rmc,
    input  logic                       enable_gga,
    output nsfe_pkg::parse_state_t     state_next,
    output logic [POS_W-1:0]           position_next,
    output logic                       emit,
    output nsfe_pkg::result_t          result
);
    import nsfe_pkg::*;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_FIELD_LEN);

    logic [2:0]       hdr_idx;
    logic [2:0]       hc_inc;
    logic             m_rmc;
    logic             m_gga;
    logic [3:0]       cnt_inc;
    logic             is_gga;
    field_sel_t       fsel;
    logic [POS_W+3:0] pos_ext;

    always_comb
    begin
        hdr_idx  = (state.header_count > 3'd4) ? 3'd4 : state.header_count;
        hc_inc   = state.header_count + 3'd1;
        m_rmc    = state.match_rmc & (rx_byte == hdr_rmc_char(hdr_idx));
        m_gga    = state.match_gga & (rx_byte == hdr_gga_char(hdr_idx));
        cnt_inc  = state.comma_count + 4'd1;
        is_gga   = ~state.match_rmc;
        fsel     = field_for(is_gga, state.comma_count);
        pos_ext  = {4'd0, position};

        state_next    = state;
        position_next = position;
        emit          = 1'b0;
        result.kind      = KIND_CHAR;
        result.sent_type = is_gga ? TYPE_GGA : TYPE_RMC;
        result.code      = fsel.code;
        result.pos       = pos_ext[3:0];
        result.value     = rx_byte;

        unique case (state.phase)
            PH_IDLE:
            begin
                if (rx_byte == CH_START) begin
                    state_next.phase        = PH_HEADER;
                    state_next.header_count = 3'd0;
                    state_next.match_rmc    = 1'b1;
                    state_next.match_gga    = 1'b1;
                end
            end
            PH_HEADER:
            begin
                state_next.match_rmc    = m_rmc;
                state_next.match_gga    = m_gga;
                state_next.header_count = hc_inc;
                if (hc_inc >= HDR_LEN) begin
                    state_next.header_count = 3'd0;
                    state_next.comma_count  = 4'd0;
                    position_next           = '0;
                    if (m_rmc && enable_rmc) begin
                        state_next.match_gga = 1'b0;
                        state_next.phase     = PH_BODY;
                    end
                    else if (m_gga && enable_gga) begin
                        state_next.match_rmc = 1'b0;
                        state_next.phase     = PH_BODY;
                    end
                    else begin
                        state_next.phase = PH_IDLE;
                    end
                end
            end
            PH_BODY:
            begin
                if (rx_byte == CH_COMMA) begin
                    state_next.comma_count = cnt_inc;
                    // In RMC the hemisphere letters continue lat and lon.
                    if (is_gga || (cnt_inc != 4'd4 && cnt_inc != 4'd6))
                        position_next = '0;
                    if (cnt_inc >= LAST_COMMA) begin
                        state_next.phase       = PH_IDLE;
                        state_next.comma_count = 4'd0;
                        position_next          = '0;
                        emit                   = 1'b1;
                        result.kind            = KIND_COMPLETE;
                        result.code            = FC_TIME;
                        result.pos             = 4'd0;
                        result.value           = 8'd0;
                    end
                end
                else if (fsel.hit && (position < POS_LIMIT)) begin
                    emit          = 1'b1;
                    position_next = position + POS_W'(1);
                end
            end
            default:
            begin
                state_next.phase = PH_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/nsfe_out_stage.sv =====
`timescale 1ns / 1ps
// Result register: holds one result word until the consumer takes it.
// Depends on nsfe_pkg.
module nsfe_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                load_emit,
    input  nsfe_pkg::result_t   load_result,
    input  logic                out_ready,
    output logic                can_load,
    output logic                out_valid,
    output nsfe_pkg::result_t   out_result
);
    import nsfe_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = ~valid_reg | out_ready;

    always_comb
    begin
        if (load)
            valid_next = load_emit;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_emit)
            result_reg <= load_result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
